// ===== src/pfp_pkg.sv =====
// ----------------------------------------------------------------------------
// Parity bit frame packer package
// Shared constants, codes and the result record of the frame packer.
// ----------------------------------------------------------------------------
package pfp_pkg;

  localparam int MAX_FIFO_BYTES_DEFAULT = 48;
  localparam int RX_CAPACITY_RESET      = 64;
  localparam int RBUF_DEPTH             = 4;

  localparam logic OP_TX = 1'b0;
  localparam logic OP_RX = 1'b1;

  typedef enum logic [1:0] {
    KIND_TX_BYTE = 2'd0,
    KIND_RX_BYTE = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        parity;
    logic [5:0]  count;
    logic [3:0]  bits;
    logic        error;
    logic        last;
  } result_t;

endpackage

// ===== src/parity_bit_frame_packer.sv =====
// ----------------------------------------------------------------------------
// Parity bit frame packer
// Packs transmit bytes with their parity bits into FIFO bytes and unpacks
// received FIFO bytes into data bytes with parity, with a frame summary.
// ----------------------------------------------------------------------------
// The block takes one request per cycle while in_ready is high and turns it
// into zero to three results in the same cycle, which enter a four-entry result
// buffer that drains one result per cycle on the output port while out_ready is
// high. A request is accepted while the buffer holds at most one result, so
// requests that give one result each flow at one per cycle while out_ready is
// high, and the k results of one request leave the output one after another.
module parity_bit_frame_packer #(
  parameter int MAX_FIFO_BYTES = pfp_pkg::MAX_FIFO_BYTES_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       opcode,
  input  logic [7:0] in_byte,
  input  logic       in_parity,
  input  logic       in_last,
  input  logic [2:0] in_last_bits,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_parity,
  output logic [5:0] out_count,
  output logic [3:0] out_bits,
  output logic       out_error,
  output logic       out_last
);

  localparam logic [5:0] MaxBytes = 6'(MAX_FIFO_BYTES);

  logic [6:0] rx_capacity;
  logic [7:0] bit_buf, bit_buf_next;
  logic [3:0] pend, pend_next;
  logic [5:0] seen, seen_next;
  logic [5:0] grps, grps_next;
  logic       ovf, ovf_next;

  pfp_pkg::result_t rbuf [pfp_pkg::RBUF_DEPTH];
  pfp_pkg::result_t rbuf_next [pfp_pkg::RBUF_DEPTH];
  logic [2:0] count, count_next;

  pfp_pkg::result_t cand [3];
  logic [2:0]       cvalid;

  logic accept, pop;

  logic [2:0]  tx_p;
  logic [7:0]  tx_base;
  logic [15:0] tx_word;
  logic        tx_full;
  logic [2:0]  tx_rem;
  logic        tx_ok0, tx_ok1, tx_need2, tx_keep2, tx_ovf;
  logic [5:0]  tx_seen1, tx_whole;

  logic        rx_in, rx_grp, rx_emit;
  logic [3:0]  rx_nb, rx_add, rx_pend;
  logic [7:0]  rx_mask, rx_buf;
  logic [15:0] rx_word;
  logic [4:0]  rx_total;
  logic [5:0]  rx_seen;

  logic [2:0] base;
  logic [1:0] slot [3];

  assign accept    = in_valid && in_ready;
  assign out_valid = (count != 3'd0);
  assign pop       = out_valid && out_ready;
  assign in_ready  = (count <= 3'd1);

  always_comb begin
    tx_p     = (pend > 4'd7) ? 3'd7 : pend[2:0];
    tx_base  = (pend > 4'd7) ? {1'b0, bit_buf[6:0]} : bit_buf;
    tx_word  = {8'd0, tx_base} | ({7'd0, in_parity, in_byte} << tx_p);
    tx_full  = (tx_p == 3'd7);
    tx_rem   = tx_full ? 3'd0 : tx_p + 3'd1;
    tx_ok0   = (seen < MaxBytes);
    tx_seen1 = seen + {5'd0, tx_ok0};
    tx_need2 = tx_full || (in_last && (tx_rem != 3'd0));
    tx_ok1   = (tx_seen1 < MaxBytes);
    tx_keep2 = tx_need2 && tx_ok1;
    tx_whole = tx_seen1 + {5'd0, tx_keep2 && tx_full};
    tx_ovf   = ovf || !tx_ok0 || (tx_need2 && !tx_ok1);

    rx_in    = (seen < MaxBytes);
    rx_nb    = (in_last && (in_last_bits != 3'd0)) ? {1'b0, in_last_bits} : 4'd8;
    rx_mask  = ~(8'hFF << rx_nb);
    rx_add   = rx_in ? rx_nb : 4'd0;
    rx_word  = {8'd0, bit_buf} |
               (rx_in ? ({8'd0, in_byte & rx_mask} << pend) : 16'd0);
    rx_total = {1'b0, pend} + {1'b0, rx_add};
    rx_grp   = (rx_total >= 5'd9);
    rx_emit  = rx_grp && ({1'b0, grps} < rx_capacity) && (grps != 6'd63);
    rx_buf   = rx_grp ? {1'b0, rx_word[15:9]} : rx_word[7:0];
    rx_pend  = rx_grp ? 4'(rx_total - 5'd9) : rx_total[3:0];
    rx_seen  = seen + {5'd0, rx_in};
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cand[i] = '0;
    end
    cvalid       = '0;
    bit_buf_next = bit_buf;
    pend_next    = pend;
    seen_next    = seen;
    grps_next    = grps;
    ovf_next     = ovf;
    if (opcode == pfp_pkg::OP_TX) begin
      cand[0].kind = pfp_pkg::KIND_TX_BYTE;
      cand[0].data = tx_word[7:0];
      cvalid[0]    = tx_ok0;
      cand[1].kind = pfp_pkg::KIND_TX_BYTE;
      cand[1].data = tx_word[15:8];
      cvalid[1]    = tx_keep2;
      cand[2].kind  = pfp_pkg::KIND_SUMMARY;
      cand[2].count = tx_ovf ? 6'd0 : tx_whole;
      cand[2].bits  = tx_ovf ? 4'd0 : {1'b0, tx_rem};
      cand[2].error = tx_ovf;
      cand[2].last  = 1'b1;
      cvalid[2]     = in_last;
      bit_buf_next  = tx_full ? 8'd0 : tx_word[15:8];
      pend_next     = {1'b0, tx_rem};
      seen_next     = tx_seen1 + {5'd0, tx_keep2};
      ovf_next      = tx_ovf;
    end else begin
      cand[0].kind   = pfp_pkg::KIND_RX_BYTE;
      cand[0].data   = rx_word[7:0];
      cand[0].parity = rx_word[8];
      cvalid[0]      = rx_emit;
      cand[1].kind   = pfp_pkg::KIND_SUMMARY;
      cand[1].data   = rx_buf;
      cand[1].count  = grps + {5'd0, rx_emit};
      cand[1].bits   = rx_pend;
      cand[1].last   = 1'b1;
      cvalid[1]      = in_last;
      bit_buf_next   = rx_buf;
      pend_next      = rx_pend;
      seen_next      = rx_seen;
      grps_next      = grps + {5'd0, rx_emit};
    end
    if (in_last) begin
      bit_buf_next = 8'd0;
      pend_next    = 4'd0;
      seen_next    = 6'd0;
      grps_next    = 6'd0;
      ovf_next     = 1'b0;
    end
  end

  always_comb begin
    base    = count - {2'd0, pop};
    slot[0] = base[1:0];
    slot[1] = 2'(base + {2'd0, cvalid[0]});
    slot[2] = 2'(base + {2'd0, cvalid[0]} + {2'd0, cvalid[1]});
    for (int j = 0; j < pfp_pkg::RBUF_DEPTH - 1; j++) begin
      rbuf_next[j] = pop ? rbuf[j + 1] : rbuf[j];
    end
    rbuf_next[pfp_pkg::RBUF_DEPTH - 1] = rbuf[pfp_pkg::RBUF_DEPTH - 1];
    count_next = base;
    if (accept) begin
      for (int j = 0; j < pfp_pkg::RBUF_DEPTH; j++) begin
        for (int i = 0; i < 3; i++) begin
          if (cvalid[i] && (slot[i] == 2'(j))) begin
            rbuf_next[j] = cand[i];
          end
        end
      end
      count_next = base + {2'd0, cvalid[0]} + {2'd0, cvalid[1]} + {2'd0, cvalid[2]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_capacity <= 7'(pfp_pkg::RX_CAPACITY_RESET);
      bit_buf     <= '0;
      pend        <= '0;
      seen        <= '0;
      grps        <= '0;
      ovf         <= 1'b0;
      count       <= '0;
    end else begin
      if (cfg_we) begin
        rx_capacity <= cfg_wdata;
      end
      if (accept) begin
        bit_buf <= bit_buf_next;
        pend    <= pend_next;
        seen    <= seen_next;
        grps    <= grps_next;
        ovf     <= ovf_next;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    rbuf <= rbuf_next;
  end

  assign out_kind   = rbuf[0].kind;
  assign out_byte   = rbuf[0].data;
  assign out_parity = rbuf[0].parity;
  assign out_count  = rbuf[0].count;
  assign out_bits   = rbuf[0].bits;
  assign out_error  = rbuf[0].error;
  assign out_last   = rbuf[0].last;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(pfp_pkg::RBUF_DEPTH))
    else $error("Result buffer count exceeds its depth.");

  a_pend_bound: assert property (@(posedge clk) disable iff (rst)
    pend <= 4'd8)
    else $error("Pending bit count exceeds one byte.");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    pop && !accept |=> count == $past(count) - 3'd1)
    else $error("Result buffer did not shrink on a lone pop.");

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    accept && in_last |=> pend == 4'd0 && seen == 6'd0 && grps == 6'd0 && !ovf)
    else $error("Frame state not cleared after a closing request.");

  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_kind == pfp_pkg::KIND_SUMMARY)
    else $error("Closing result is not a summary.");

endmodule
